// ----- src/lfo_modulated_chorus_unit_defines.svh -----
// Assertion helpers shared by the chorus RTL.
`ifndef LFO_MODULATED_CHORUS_UNIT_DEFINES_SVH
`define LFO_MODULATED_CHORUS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define LMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lmc_pkg.sv -----
`timescale 1ns / 1ps

package lmc_pkg;

  localparam int DELAY_LEN       = 2048;
  localparam int ADDR_W          = $clog2(DELAY_LEN);
  localparam int FILL_W          = $clog2(DELAY_LEN + 1);
  localparam int SAMPLE_W        = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_W           = SINE_TABLE_BITS - 2;
  localparam int QTR_LEN         = 1 << QTR_W;
  localparam int PHASE_W         = 32;
  localparam int SINE_W          = 16;
  localparam int SINE_MAG_W      = SINE_W - 1;
  localparam int FRAC_W          = 15;

  localparam int WET_W      = 16;
  localparam int BASE_W     = 11;
  localparam int DEPTH_W    = 10;
  localparam int STEP_W     = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_WET_GAIN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_DELAY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd3;

  localparam logic [WET_W-1:0]   WET_RST   = 16'd16384;
  localparam logic [BASE_W-1:0]  BASE_RST  = 11'd960;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 10'd96;
  localparam logic [STEP_W-1:0]  STEP_RST  = 31'd89478;

  localparam logic [WET_W-1:0] UNITY_Q15 = 16'd32768;

  // Delay arithmetic widths.
  localparam int PROD_W = DEPTH_W + 1 + SINE_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int OFS_W  = RND_W - FRAC_W;
  localparam int DLY_W  = OFS_W + 1;

  // Mix arithmetic widths.
  localparam int ACC_W = WET_W + 1 + SAMPLE_W;
  localparam int Y_W   = ACC_W - FRAC_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_MAG_W-1:0] sine_tab_t [0:QTR_LEN];

  typedef struct packed {
    logic [WET_W-1:0]   wet_gain;
    logic [BASE_W-1:0]  base_delay;
    logic [DEPTH_W-1:0] depth_samples;
    logic [STEP_W-1:0]  phase_step;
  } lmc_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]          rd;
    logic [ADDR_W-1:0]          wr;
  } lmc_job_t;

  // Quarter-wave sine table in Q15, built from a Taylor series in Q30.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        ang;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    int unsigned        i;
    int unsigned        k;
    for (i = 0; i <= QTR_LEN; i++) begin
      ang  = (64'(i) * HALF_PI_Q30) / 64'(QTR_LEN);
      x2   = (ang * ang) >> 30;
      term = ang;
      sum  = $signed(ang);
      for (k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        unique case (k)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32767) begin
        q = 64'sd32767;
      end
      tab[i] = SINE_MAG_W'(q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_QTR = build_sine_tab();

  function automatic logic signed [SINE_W-1:0] lfo_sine(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]            quad;
    logic [QTR_W-1:0]      j;
    logic [QTR_W:0]        jr;
    logic [SINE_MAG_W-1:0] mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    j    = idx[QTR_W-1:0];
    jr   = (QTR_W + 1)'(QTR_LEN) - {1'b0, j};
    if (quad[0]) begin
      mag = SINE_QTR[jr];
    end else begin
      mag = SINE_QTR[{1'b0, j}];
    end
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end else begin
      return $signed({1'b0, mag});
    end
  endfunction

endpackage

// ----- src/lmc_ram.sv -----
`timescale 1ns / 1ps

module lmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lmc_front.sv -----
`timescale 1ns / 1ps

module lmc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lmc_pkg::lmc_cfg_t                  cfg,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [lmc_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               q_push,
  output lmc_pkg::lmc_job_t                  q_job,
  input  logic                               q_full
);
  import lmc_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_ADR  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [ADDR_W-1:0]          widx_r, widx_nxt;
  logic [ADDR_W-1:0]          wr_r, wr_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [SINE_W-1:0]   sine_r, sine_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;

  logic signed [DEPTH_W:0]  depth_s;
  logic signed [RND_W-1:0]  prod_rnd;
  logic signed [DLY_W-1:0]  dly_raw;
  logic [ADDR_W-1:0]        dly;

  assign depth_s  = $signed({1'b0, cfg.depth_samples});
  assign prod_rnd = $signed({prod_r[PROD_W-1], prod_r}) + RND_W'(16384);
  assign dly_raw  = $signed(DLY_W'(cfg.base_delay))
                  + $signed({prod_rnd[RND_W-1], prod_rnd[RND_W-1:FRAC_W]});

  always_comb begin
    if (dly_raw < 0) begin
      dly = '0;
    end else if (dly_raw > $signed(DLY_W'(DELAY_LEN - 1))) begin
      dly = ADDR_W'(DELAY_LEN - 1);
    end else begin
      dly = dly_raw[ADDR_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    widx_nxt   = widx_r;
    wr_nxt     = wr_r;
    sample_nxt = sample_r;
    sine_nxt   = sine_r;
    prod_nxt   = prod_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          sample_nxt = in_sample;
          sine_nxt   = lfo_sine(phase_r[PHASE_W-1 -: SINE_TABLE_BITS]);
          wr_nxt     = widx_r;
          widx_nxt   = widx_r + 1'b1;
          phase_nxt  = phase_r + PHASE_W'(cfg.phase_step);
          state_nxt  = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt  = depth_s * sine_r;
        state_nxt = F_ADR;
      end
      F_ADR: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= '0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      widx_r  <= widx_nxt;
    end
    wr_r     <= wr_nxt;
    sample_r <= sample_nxt;
    sine_r   <= sine_nxt;
    prod_r   <= prod_nxt;
  end

  assign in_full      = (state_r != F_IDLE);
  assign q_push       = (state_r == F_ADR) && !q_full;
  assign q_job.sample = sample_r;
  assign q_job.rd     = wr_r - dly;
  assign q_job.wr     = wr_r;

endmodule

// ----- src/lmc_queue.sv -----
`timescale 1ns / 1ps
`include "lfo_modulated_chorus_unit_defines.svh"

module lmc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lmc_pkg::lmc_job_t push_job,
  output logic              full,
  input  logic              pop,
  output lmc_pkg::lmc_job_t head_job,
  output logic              empty
);
  import lmc_pkg::*;

  lmc_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  `LMC_ASSERT_IMP(a_q_count_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH),
                  "queue count exceeds its depth")
  `LMC_ASSERT_IMP(a_q_no_overflow, push, !full, "transaction pushed into a full queue")

endmodule

// ----- src/lmc_back.sv -----
`timescale 1ns / 1ps
`include "lfo_modulated_chorus_unit_defines.svh"

module lmc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmc_pkg::lmc_cfg_t                   cfg,
  input  lmc_pkg::lmc_job_t                   q_job,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [lmc_pkg::SAMPLE_W-1:0] out_sample
);
  import lmc_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MAC  = 2'd1;
  localparam logic [1:0] B_FIN  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  lmc_job_t                   job_r, job_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    sum_r, sum_nxt;
  logic                       tap_ok_r, tap_ok_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic [WET_W-1:0]           wet;
  logic [WET_W-1:0]           dry;
  logic signed [WET_W:0]      wet_s;
  logic signed [WET_W:0]      dry_s;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [Y_W-1:0]      y_raw;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       ram_we;

  assign wet   = (cfg.wet_gain > UNITY_Q15) ? UNITY_Q15 : cfg.wet_gain;
  assign dry   = UNITY_Q15 - wet;
  assign wet_s = $signed({1'b0, wet});
  assign dry_s = $signed({1'b0, dry});
  assign tap   = tap_ok_r ? $signed(ram_rdata) : '0;
  assign y_raw = sum_r[ACC_W-1:FRAC_W];

  always_comb begin
    if (y_raw > $signed(Y_W'((1 << (SAMPLE_W - 1)) - 1))) begin
      y_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (y_raw < -$signed(Y_W'(1 << (SAMPLE_W - 1)))) begin
      y_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      y_sat = y_raw[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    tap_ok_nxt    = tap_ok_r;
    fill_nxt      = fill_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          job_nxt    = q_job;
          acc_nxt    = dry_s * q_job.sample + $signed(ACC_W'(16384));
          tap_ok_nxt = ({1'b0, q_job.rd} < fill_r);
          state_nxt  = B_MAC;
        end
      end
      B_MAC: begin
        sum_nxt   = acc_r + wet_s * tap;
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (!out_valid_r || out_pop) begin
          ram_we        = 1'b1;
          out_data_nxt  = y_sat;
          out_valid_nxt = 1'b1;
          if (fill_r != FILL_W'(DELAY_LEN)) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    tap_ok_r   <= tap_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  lmc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_LEN)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job_r.wr),
    .wdata (job_r.sample),
    .raddr (q_job.rd),
    .rdata (ram_rdata)
  );

  assign out_empty  = !out_valid_r;
  assign out_sample = out_data_r;

  `LMC_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FILL_W'(DELAY_LEN),
                  "fill count exceeds the delay line length")
  `LMC_ASSERT_NEXT(a_write_loads_out, ram_we, out_valid_r,
                   "delay line written without a result transaction")
  `LMC_ASSERT_IMP(a_pop_needs_entry, q_pop, !q_empty && state_r == B_IDLE,
                  "queue popped while empty or busy")

endmodule

// ----- src/lfo_modulated_chorus_unit.sv -----
`timescale 1ns / 1ps
// Chorus effect: each input transaction carries one signed 16-bit sample and
// produces exactly one mixed output transaction, in order. A sine LFO moves a
// read tap around base_delay in a 2048-sample delay line, and the output is
// the Q1.15 wet/dry mix of the input and the tapped sample, saturated. The
// front steps each sample through table lookup, depth multiply and tap
// address, stalling while the queue is full, and the back retires each one
// through delay line read and dry product, wet product, then saturate and
// write back, stalling while the output is held. Neither half takes a new
// sample before it is through with the last one. A two-entry
// queue decouples the two halves. The delay line needs no clearing pass after
// reset: entries not yet written read as zero. Configuration registers are
// written through cfg_we/cfg_addr/cfg_data and must only change while idle.

module lfo_modulated_chorus_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [lmc_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [lmc_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                  cfg_we,
  input  logic [lmc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lmc_pkg::*;

  lmc_cfg_t cfg_r;
  lmc_job_t front_job;
  lmc_job_t head_job;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wet_gain      <= WET_RST;
      cfg_r.base_delay    <= BASE_RST;
      cfg_r.depth_samples <= DEPTH_RST;
      cfg_r.phase_step    <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WET_GAIN:   cfg_r.wet_gain      <= cfg_data[WET_W-1:0];
        REG_BASE_DELAY: cfg_r.base_delay    <= cfg_data[BASE_W-1:0];
        REG_DEPTH:      cfg_r.depth_samples <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP: cfg_r.phase_step    <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample_in),
    .q_push    (q_push),
    .q_job     (front_job),
    .q_full    (q_full)
  );

  lmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  lmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_job      (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample_out)
  );

endmodule

// ----- sim/lfo_modulated_chorus_unit_tb.sv -----
`timescale 1ns / 1ps

module lfo_modulated_chorus_unit_tb;
  import lmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 57;

  class chorus_scoreboard;
    int unsigned                sine_qtr [0:QTR_LEN];
    logic [WET_W-1:0]           wet_gain;
    logic [BASE_W-1:0]          base_delay;
    logic [DEPTH_W-1:0]         depth_samples;
    logic [STEP_W-1:0]          phase_step;
    logic signed [SAMPLE_W-1:0] delay_line [0:DELAY_LEN-1];
    logic [ADDR_W-1:0]          wr_idx;
    logic [PHASE_W-1:0]         lfo_phase;
    logic signed [SAMPLE_W-1:0] mix_expected [$];
    int                         errors;

    function new();
      longint unsigned ang;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          q;
      for (int i = 0; i <= QTR_LEN; i++) begin
        ang  = (longint'(i) * HALF_PI_Q30) / QTR_LEN;
        x2   = (ang * ang) >> 30;
        term = ang;
        sum  = ang;
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        q = (sum + 16384) >>> 15;
        if (q > 32767) begin
          q = 32767;
        end
        sine_qtr[i] = q;
      end
      wet_gain      = WET_RST;
      base_delay    = BASE_RST;
      depth_samples = DEPTH_RST;
      phase_step    = STEP_RST;
      foreach (delay_line[i]) delay_line[i] = '0;
      wr_idx    = '0;
      lfo_phase = '0;
      errors    = 0;
    endfunction

    function int sine_at(logic [PHASE_W-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      int                         j;
      idx = ph[PHASE_W-1 -: SINE_TABLE_BITS];
      j   = idx[QTR_W-1:0];
      case (idx[SINE_TABLE_BITS-1 -: 2])
        2'd0:    return sine_qtr[j];
        2'd1:    return sine_qtr[QTR_LEN - j];
        2'd2:    return -int'(sine_qtr[j]);
        default: return -int'(sine_qtr[QTR_LEN - j]);
      endcase
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WET_GAIN:   wet_gain      = data[WET_W-1:0];
        REG_BASE_DELAY: base_delay    = data[BASE_W-1:0];
        REG_DEPTH:      depth_samples = data[DEPTH_W-1:0];
        REG_PHASE_STEP: phase_step    = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      int                         s;
      longint                     dly;
      longint                     wet;
      longint                     acc;
      longint                     y;
      logic [ADDR_W-1:0]          rd;
      logic signed [SAMPLE_W-1:0] tap;
      s   = sine_at(lfo_phase);
      dly = longint'(base_delay) + ((longint'(depth_samples) * s + 16384) >>> 15);
      if (dly < 0) begin
        dly = 0;
      end
      if (dly > DELAY_LEN - 1) begin
        dly = DELAY_LEN - 1;
      end
      rd  = wr_idx - ADDR_W'(dly);
      tap = delay_line[rd];
      wet = (wet_gain > UNITY_Q15) ? 32768 : longint'(wet_gain);
      acc = (32768 - wet) * longint'(x) + wet * longint'(tap) + 16384;
      y   = acc >>> 15;
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      delay_line[wr_idx] = x;
      wr_idx             = wr_idx + 1'b1;
      lfo_phase          = lfo_phase + PHASE_W'(phase_step);
      mix_expected.push_back(y[SAMPLE_W-1:0]);
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] y);
      logic signed [SAMPLE_W-1:0] want;
      if (mix_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, actual %0d", $time, y);
      end else begin
        want = mix_expected.pop_front();
        if (y !== want) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, y);
        end
      end
    endfunction

    function int outstanding();
      return mix_expected.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic signed [SAMPLE_W-1:0]   in_sample_in;
  logic                         out_empty;
  logic                         out_pop;
  logic signed [SAMPLE_W-1:0]   out_sample_out;
  logic                         cfg_we;
  logic [CFG_ADDR_W-1:0]        cfg_addr;
  logic [CFG_DATA_W-1:0]        cfg_data;

  chorus_scoreboard sb;
  int               quiet_cycles = 0;
  int               rx_hold = 0;
  bit               rx_idle = 1'b0;

  lfo_modulated_chorus_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_in   (in_sample_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_sample(in_sample_in);
      end
      if (out_pop && !out_empty) begin
        sb.check_sample(out_sample_out);
      end
      if (cfg_we) begin
        sb.write_reg(cfg_addr, cfg_data);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 16'sh7FFF;
    end
    if (r == 1) begin
      return 16'sh8000;
    end
    return SAMPLE_W'($urandom);
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int g;
    out_pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        g       = rx_hold;
        rx_hold = 0;
      end else begin
        g = gap_len(rx_idle);
      end
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  task automatic send_samples(input logic signed [SAMPLE_W-1:0] vals[$], input bit idle_on);
    int g;
    for (int i = 0; i < vals.size(); i++) begin
      in_push      <= 1'b1;
      in_sample_in <= vals[i];
      do @(posedge clk); while (in_full);
      @(negedge clk);
      g = gap_len(idle_on);
      if (i == vals.size() - 1 && g == 0) begin
        g = 1;
      end
      if (g > 0) begin
        in_push <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  task automatic send_random(input int count, input bit idle_on);
    logic signed [SAMPLE_W-1:0] vals[$];
    repeat (count) vals.push_back(pick_sample());
    send_samples(vals, idle_on);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Bits above each register's width carry random values and must be ignored.
  task automatic write_regs(input logic [WET_W-1:0] wet, input logic [BASE_W-1:0] base,
                            input logic [DEPTH_W-1:0] depth, input logic [STEP_W-1:0] step);
    logic [CFG_DATA_W-1:0] data [4];
    logic [CFG_ADDR_W-1:0] addr [4];
    for (int i = 0; i < 4; i++) data[i] = CFG_DATA_W'($urandom);
    data[0][WET_W-1:0]   = wet;
    data[1][BASE_W-1:0]  = base;
    data[2][DEPTH_W-1:0] = depth;
    data[3][STEP_W-1:0]  = step;
    addr[0] = REG_WET_GAIN;
    addr[1] = REG_BASE_DELAY;
    addr[2] = REG_DEPTH;
    addr[3] = REG_PHASE_STEP;
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= addr[i];
      cfg_data <= data[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_random_regs();
    logic [WET_W-1:0]   wet;
    logic [BASE_W-1:0]  base;
    logic [DEPTH_W-1:0] depth;
    logic [STEP_W-1:0]  step;
    case ($urandom_range(0, 5))
      0:       wet = '0;
      1:       wet = UNITY_Q15;
      2:       wet = $urandom_range(32769, 65535);
      default: wet = $urandom_range(0, 32768);
    endcase
    case ($urandom_range(0, 5))
      0:       base = '0;
      1:       base = '1;
      2:       base = $urandom_range(0, 2047);
      default: base = $urandom_range(0, 120);
    endcase
    case ($urandom_range(0, 4))
      0:       depth = '0;
      1:       depth = '1;
      2:       depth = $urandom_range(0, 40);
      default: depth = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 4))
      0:       step = '0;
      1:       step = '1;
      2:       step = $urandom_range(1, 1 << 22);
      default: step = STEP_W'($urandom);
    endcase
    write_regs(wet, base, depth, step);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] vals[$];
    bit                         tx_idle;
    sb           = new();
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_sample_in = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings with extreme samples.
    vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA};
    send_samples(vals, 1'b1);
    wait_drained();

    // Wet gain above unity, zero delay, frozen LFO.
    write_regs(16'hFFFF, '0, '0, '0);
    vals = '{16'sh1234, 16'sh8000, 16'sh7FFF};
    send_samples(vals, 1'b1);
    wait_drained();

    // Largest delay and depth: the tap is clamped at the top of the line.
    write_regs(UNITY_Q15, '1, '1, '1);
    vals = '{16'sh7FFF, 16'sh8000, 16'sh4000, 16'shC000};
    send_samples(vals, 1'b0);
    wait_drained();

    // Dry only, LFO stepping by quadrants: negative delays clamp to zero.
    write_regs('0, '0, '1, STEP_W'(1 << 30));
    vals = '{16'sh0100, 16'shFF00, 16'sh7FFF, 16'sh8000};
    send_samples(vals, 1'b1);
    wait_drained();

    write_regs(16'd8192, 11'd3, 10'd5, STEP_W'(1 << 29));
    vals = '{16'sh0F0F, 16'shF0F0, 16'sh3C3C, 16'shC3C3};
    send_samples(vals, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_random_regs();
      tx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        rx_hold = 80;
        send_random(24, 1'b0);
        send_random(PHASE_ITEMS - 24, tx_idle);
      end else if (p == 6) begin
        send_random(PHASE_ITEMS / 2, tx_idle);
        wait_drained();
        send_random(PHASE_ITEMS - PHASE_ITEMS / 2, tx_idle);
      end else begin
        send_random(PHASE_ITEMS, tx_idle);
      end
      wait_drained();
    end

    rx_idle = 1'b1;
    write_regs(16'd24576, '1, '1, STEP_W'($urandom));
    send_random(40, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/lmc_pkg.sv
src/lmc_ram.sv
src/lmc_front.sv
src/lmc_queue.sv
src/lmc_back.sv
src/lfo_modulated_chorus_unit.sv
sim/lfo_modulated_chorus_unit_tb.sv
